### hw/rtl/rr_pkg.sv
// Package for the right-to-left run reorder block.
// Holds widths, codepoint constants, register indexes and the sequencer state type.
// Used by rr_ram and rtl_run_reorder.
package rr_pkg;

  localparam int unsigned CP_W          = 21;
  localparam int unsigned RUN_DEPTH_DEF = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
  localparam logic [CP_W-1:0] CP_TAB   = 21'h00009;

  localparam logic [CP_W-1:0] RANGE_LOW_RST  = 21'h00590;
  localparam logic [CP_W-1:0] RANGE_HIGH_RST = 21'h005FF;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } rr_state_e;

endpackage

### hw/rtl/rr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds when no read is issued. Depends on rr_pkg for default width.
module rr_ram
  import rr_pkg::*;
#(
  parameter int unsigned WIDTH = CP_W,
  parameter int unsigned DEPTH = RUN_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/rtl_run_reorder.sv
// Top level of the right-to-left run reorder block: run RAM, flush sequencer, output stage.
// Depends on rr_pkg and rr_ram.
//
// Codepoints are taken one transfer at a time while the sequencer is idle. A codepoint that
// joins a run is written to the run RAM in the cycle it is accepted and, unless it ends the
// line or fills the run RAM, gives no result. A codepoint outside any run passes through a
// one-entry tail register. A flush reads the run RAM one entry per cycle, forwarding each
// read into the output register as it frees up; a new read waits while the one before is held.
// A breaking codepoint that follows the run waits in the tail register until the last read
// has moved into the output register. Otherwise the next codepoint is taken in the cycle
// after the last RAM read is issued. A stalled output holds back both reads and the tail.
// The run RAM needs no clearing after reset.
module rtl_run_reorder
  import rr_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CP_W-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CP_W-1:0]      codepoint_i,
  input  logic                 line_end_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [CP_W-1:0]      out_codepoint_o,
  output logic                 batch_last_o,
  output logic                 line_done_o,
  output logic                 run_overflow_o
);

  localparam int unsigned AW = $clog2(RUN_DEPTH);
  localparam int unsigned FW = $clog2(RUN_DEPTH + 1);

  rr_state_e state_q, state_d;

  logic [CP_W-1:0] range_lo_q, range_hi_q;
  logic [FW-1:0]   fill_q, fill_d;
  logic [AW-1:0]   last_q, last_d;

  logic [AW-1:0]   rd_addr_q, rd_addr_d;
  logic            fwd_q, fwd_d;
  logic [FW-1:0]   rem_q, rem_d;
  logic [AW-1:0]   fl_last_q, fl_last_d;
  logic            fl_ovf_q, fl_ovf_d;
  logic            fl_end_q, fl_end_d;
  logic            tail_q, tail_d;
  logic [CP_W-1:0] tail_cp_q, tail_cp_d;
  logic            tail_done_q, tail_done_d;

  logic            pend_q, pend_d;
  logic            pend_last_q, pend_last_d;
  logic            pend_done_q, pend_done_d;
  logic            pend_ovf_q, pend_ovf_d;

  logic            out_v_q, out_v_d;
  logic [CP_W-1:0] out_cp_q, out_cp_d;
  logic            out_last_q, out_last_d;
  logic            out_done_q, out_done_d;
  logic            out_ovf_q, out_ovf_d;

  logic            in_xfer, is_rtl, is_gap, open_run, out_free, move, tail_mv;
  logic            rd_en, wr_en;
  logic [AW-1:0]   wr_addr;
  logic [FW-1:0]   new_fill;
  logic [CP_W-1:0] rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_rtl     = (codepoint_i >= range_lo_q) && (codepoint_i <= range_hi_q);
  assign is_gap     = (codepoint_i == CP_SPACE) || (codepoint_i == CP_TAB);
  assign open_run   = (fill_q != '0);
  assign new_fill   = fill_q + 1'b1;
  assign wr_addr    = fill_q[AW-1:0];
  assign wr_en      = in_xfer && (is_rtl || (open_run && is_gap));
  assign out_free   = !out_v_q || out_ready_i;
  assign move       = pend_q && out_free;
  assign rd_en      = (state_q == ST_FLUSH) && (!pend_q || move);
  assign tail_mv    = (state_q == ST_TAIL) && !pend_q && out_free;

  rr_ram #(
    .WIDTH(CP_W),
    .DEPTH(RUN_DEPTH)
  ) u_run_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(codepoint_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo_q <= RANGE_LOW_RST;
      range_hi_q <= RANGE_HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RANGE_LOW:  range_lo_q <= cfg_wdata_i;
        REG_RANGE_HIGH: range_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      last_q  <= '0;
      rem_q   <= '0;
      fwd_q   <= 1'b0;
      tail_q  <= 1'b0;
      pend_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      last_q  <= last_d;
      rem_q   <= rem_d;
      fwd_q   <= fwd_d;
      tail_q  <= tail_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q   <= rd_addr_d;
    fl_last_q   <= fl_last_d;
    fl_ovf_q    <= fl_ovf_d;
    fl_end_q    <= fl_end_d;
    tail_cp_q   <= tail_cp_d;
    tail_done_q <= tail_done_d;
    pend_last_q <= pend_last_d;
    pend_done_q <= pend_done_d;
    pend_ovf_q  <= pend_ovf_d;
    out_cp_q    <= out_cp_d;
    out_last_q  <= out_last_d;
    out_done_q  <= out_done_d;
    out_ovf_q   <= out_ovf_d;
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    last_d      = last_q;
    rd_addr_d   = rd_addr_q;
    fwd_d       = fwd_q;
    rem_d       = rem_q;
    fl_last_d   = fl_last_q;
    fl_ovf_d    = fl_ovf_q;
    fl_end_d    = fl_end_q;
    tail_d      = tail_q;
    tail_cp_d   = tail_cp_q;
    tail_done_d = tail_done_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          tail_cp_d   = codepoint_i;
          tail_done_d = line_end_i;
          tail_d      = 1'b0;
          fl_ovf_d    = 1'b0;
          fl_end_d    = line_end_i;
          fwd_d       = 1'b0;
          if (!open_run && !is_rtl) begin
            tail_d  = 1'b1;
            state_d = ST_TAIL;
          end else if (!open_run) begin
            fill_d = FW'(1);
            last_d = '0;
            if (line_end_i) begin
              rd_addr_d = '0;
              fl_last_d = '0;
              rem_d     = FW'(1);
              fill_d    = '0;
              state_d   = ST_FLUSH;
            end
          end else if (is_rtl || is_gap) begin
            fill_d = new_fill;
            if (is_rtl) begin
              last_d = fill_q[AW-1:0];
            end
            if (line_end_i || (new_fill == FW'(RUN_DEPTH))) begin
              fl_ovf_d  = !line_end_i;
              rd_addr_d = is_rtl ? fill_q[AW-1:0] : last_q;
              fl_last_d = is_rtl ? fill_q[AW-1:0] : last_q;
              rem_d     = new_fill;
              fill_d    = '0;
              last_d    = '0;
              state_d   = ST_FLUSH;
            end
          end else begin
            tail_d    = 1'b1;
            rd_addr_d = last_q;
            fl_last_d = last_q;
            rem_d     = fill_q;
            fill_d    = '0;
            last_d    = '0;
            state_d   = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (rd_en) begin
          rem_d = rem_q - 1'b1;
          if (fwd_q) begin
            rd_addr_d = rd_addr_q + 1'b1;
          end else if (rd_addr_q == '0) begin
            rd_addr_d = fl_last_q + 1'b1;
            fwd_d     = 1'b1;
          end else begin
            rd_addr_d = rd_addr_q - 1'b1;
          end
          if (rem_q == FW'(1)) begin
            state_d = tail_q ? ST_TAIL : ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        if (tail_mv) begin
          tail_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    pend_done_d = pend_done_q;
    pend_ovf_d  = pend_ovf_q;
    if (rd_en) begin
      pend_d      = 1'b1;
      pend_last_d = (rem_q == FW'(1)) && !tail_q;
      pend_done_d = (rem_q == FW'(1)) && !tail_q && fl_end_q;
      pend_ovf_d  = fl_ovf_q;
    end else if (move) begin
      pend_d = 1'b0;
    end

    out_v_d    = out_v_q && !out_ready_i;
    out_cp_d   = out_cp_q;
    out_last_d = out_last_q;
    out_done_d = out_done_q;
    out_ovf_d  = out_ovf_q;
    if (move) begin
      out_v_d    = 1'b1;
      out_cp_d   = rdata;
      out_last_d = pend_last_q;
      out_done_d = pend_done_q;
      out_ovf_d  = pend_ovf_q;
    end else if (tail_mv) begin
      out_v_d    = 1'b1;
      out_cp_d   = tail_cp_q;
      out_last_d = 1'b1;
      out_done_d = tail_done_q;
      out_ovf_d  = 1'b0;
    end
  end

  assign out_valid_o     = out_v_q;
  assign out_codepoint_o = out_cp_q;
  assign batch_last_o    = out_last_q;
  assign line_done_o     = out_done_q;
  assign run_overflow_o  = out_ovf_q;

  a_flush_has_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (rem_q != '0))
    else $error("flush sequencer active with no reads left");

  a_no_write_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_IDLE))
    else $error("run RAM written while not idle");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FW'(RUN_DEPTH))
    else $error("run fill reached depth without flush");

  a_pass_to_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !open_run && !is_rtl) |=> (state_q == ST_TAIL && tail_q))
    else $error("pass-through codepoint not routed to tail");

endmodule

### sim/rr_order_checker.sv
`timescale 1ns / 1ps
// Checker for rtl_run_reorder: follows config writes and both transfer channels, predicts
// the visual order of every line and compares each result field by field. Depends on rr_pkg.
module rr_order_checker
  import rr_pkg::*;
#(
  parameter int unsigned RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CP_W-1:0]      cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [CP_W-1:0]      codepoint_i,
  input  logic                 line_end_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [CP_W-1:0]      out_codepoint_i,
  input  logic                 batch_last_i,
  input  logic                 line_done_i,
  input  logic                 run_overflow_i,
  output logic [31:0]          fail_cnt_o,
  output logic [31:0]          pending_o,
  output logic [31:0]          results_o,
  output logic [31:0]          overflows_o
);

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            batch_last;
    logic            line_done;
    logic            overflow;
  } visual_cp_t;

  visual_cp_t      visual_q[$];
  visual_cp_t      step_out[RUN_DEPTH+1];
  int unsigned     step_cnt;
  logic [CP_W-1:0] run_buf[RUN_DEPTH];
  int unsigned     run_len;
  int unsigned     last_rtl_idx;
  logic [CP_W-1:0] rtl_lo;
  logic [CP_W-1:0] rtl_hi;
  int unsigned     fail_cnt;
  int unsigned     result_cnt;
  int unsigned     overflow_cnt;

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
    fail_cnt++;
  endtask

  task automatic emit_cp(input logic [CP_W-1:0] cp, input logic ovf);
    step_out[step_cnt] = '{cp: cp, batch_last: 1'b0, line_done: 1'b0, overflow: ovf};
    step_cnt++;
  endtask

  task automatic flush_run(input logic ovf);
    int unsigned last;
    int unsigned i;
    last = last_rtl_idx;
    if (last >= run_len) last = run_len - 1;
    for (i = last + 1; i > 0; i--) emit_cp(run_buf[i-1], ovf);
    for (i = last + 1; i < run_len; i++) emit_cp(run_buf[i], ovf);
    run_len      = 0;
    last_rtl_idx = 0;
  endtask

  task automatic predict_visual_order(input logic [CP_W-1:0] cp, input logic line_end);
    logic        rtl;
    logic        gap;
    int unsigned i;
    rtl      = (cp >= rtl_lo) && (cp <= rtl_hi);
    gap      = (cp == CP_SPACE) || (cp == CP_TAB);
    step_cnt = 0;
    if (run_len == 0) begin
      if (rtl) begin
        run_buf[0]   = cp;
        run_len      = 1;
        last_rtl_idx = 0;
        if (line_end) flush_run(1'b0);
      end else begin
        emit_cp(cp, 1'b0);
      end
    end else if (rtl || gap) begin
      if (run_len < RUN_DEPTH) begin
        run_buf[run_len] = cp;
        if (rtl) last_rtl_idx = run_len;
        run_len++;
      end
      if (line_end) flush_run(1'b0);
      else if (run_len >= RUN_DEPTH) flush_run(1'b1);
    end else begin
      flush_run(1'b0);
      emit_cp(cp, 1'b0);
    end
    if (step_cnt > 0) begin
      step_out[step_cnt-1].batch_last = 1'b1;
      step_out[step_cnt-1].line_done  = line_end;
    end
    for (i = 0; i < step_cnt; i++) visual_q.push_back(step_out[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    visual_cp_t want;
    if (!rst_ni) begin
      visual_q.delete();
      run_len      = 0;
      last_rtl_idx = 0;
      rtl_lo       = RANGE_LOW_RST;
      rtl_hi       = RANGE_HIGH_RST;
      fail_cnt     = 0;
      result_cnt   = 0;
      overflow_cnt = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_RANGE_LOW) rtl_lo = cfg_wdata_i;
        else if (cfg_index_i == REG_RANGE_HIGH) rtl_hi = cfg_wdata_i;
      end
      if (out_valid_i && out_ready_i) begin
        result_cnt++;
        if (run_overflow_i === 1'b1) overflow_cnt++;
        if (visual_q.size() == 0) begin
          report_mismatch("unrequested result, out_codepoint", 0, 32'(out_codepoint_i));
        end else begin
          want = visual_q.pop_front();
          if (out_codepoint_i !== want.cp)
            report_mismatch("out_codepoint", 32'(want.cp), 32'(out_codepoint_i));
          if (batch_last_i !== want.batch_last)
            report_mismatch("batch_last", 32'(want.batch_last), 32'(batch_last_i));
          if (line_done_i !== want.line_done)
            report_mismatch("line_done", 32'(want.line_done), 32'(line_done_i));
          if (run_overflow_i !== want.overflow)
            report_mismatch("run_overflow", 32'(want.overflow), 32'(run_overflow_i));
        end
      end
      if (in_valid_i && in_ready_i) predict_visual_order(codepoint_i, line_end_i);
    end
    fail_cnt_o  <= fail_cnt;
    pending_o   <= visual_q.size();
    results_o   <= result_cnt;
    overflows_o <= overflow_cnt;
  end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench top for rtl_run_reorder: clock, reset, config writes and codepoint stimulus.
// Depends on rr_pkg, rtl_run_reorder and rr_order_checker, which does all the checking.
module tb
  import rr_pkg::*;
();

  localparam int unsigned RUN_DEPTH    = RUN_DEPTH_DEF;
  localparam int unsigned DRAIN_CYCLES = 2 * RUN_DEPTH + 8;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [CP_W-1:0]      CP_MAX      = 21'h1FFFFF;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CP_W-1:0]      cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [CP_W-1:0]      codepoint_i;
  logic                 line_end_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [CP_W-1:0]      out_codepoint_o;
  logic                 batch_last_o;
  logic                 line_done_o;
  logic                 run_overflow_o;

  logic [31:0]     fail_cnt;
  logic [31:0]     pending;
  logic [31:0]     results;
  logic [31:0]     overflows;

  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     items_sent;
  int unsigned     cycle_cnt;
  logic            long_hold_req;
  logic            long_hold_done;
  logic [CP_W-1:0] cur_lo;
  logic [CP_W-1:0] cur_hi;
  logic [CP_W-1:0] line_buf[$];

  rtl_run_reorder #(
    .RUN_DEPTH(RUN_DEPTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .codepoint_i    (codepoint_i),
    .line_end_i     (line_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_codepoint_o(out_codepoint_o),
    .batch_last_o   (batch_last_o),
    .line_done_o    (line_done_o),
    .run_overflow_o (run_overflow_o)
  );

  rr_order_checker #(
    .RUN_DEPTH(RUN_DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .codepoint_i    (codepoint_i),
    .line_end_i     (line_end_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_codepoint_i(out_codepoint_o),
    .batch_last_i   (batch_last_o),
    .line_done_i    (line_done_o),
    .run_overflow_i (run_overflow_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .results_o      (results),
    .overflows_o    (overflows)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : receiver
    long_hold_done <= 1'b0;
    out_ready_i    <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done <= 1'b1;
      end
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic in_rtl_range(input logic [CP_W-1:0] cp);
    return (cp >= cur_lo) && (cp <= cur_hi);
  endfunction

  function automatic logic [CP_W-1:0] gap_cp();
    return $urandom_range(1) ? CP_SPACE : CP_TAB;
  endfunction

  function automatic logic [CP_W-1:0] rtl_cp();
    logic [CP_W-1:0] cp;
    if (cur_lo <= cur_hi) cp = CP_W'($urandom_range(cur_hi, cur_lo));
    else cp = CP_W'($urandom);
    return cp;
  endfunction

  function automatic logic [CP_W-1:0] ltr_cp();
    logic [CP_W-1:0] cp;
    int unsigned     tries;
    tries = 0;
    do begin
      if ($urandom_range(3) == 0) cp = CP_W'($urandom);
      else cp = CP_W'($urandom_range(8'h7E, 8'h21));
      tries++;
    end while ((in_rtl_range(cp) || cp == CP_SPACE || cp == CP_TAB) && tries < 16);
    return cp;
  endfunction

  task automatic send_cp(input logic [CP_W-1:0] cp, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    codepoint_i <= cp;
    line_end_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CP_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_range(input logic [CP_W-1:0] lo, input logic [CP_W-1:0] hi);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_SPARE_A, CP_W'($urandom));
    write_reg(REG_SPARE_B, ~lo);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_lo = lo;
    cur_hi = hi;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic fill_lines(input int unsigned goal);
    int unsigned     kind;
    int unsigned     len;
    int unsigned     j;
    logic [CP_W-1:0] noise;
    while (items_sent < goal) begin
      line_buf.delete();
      repeat ($urandom_range(4, 1)) begin
        kind = $urandom_range(9);
        if (kind < 2) begin
          repeat ($urandom_range(3, 1)) line_buf.push_back(ltr_cp());
        end else if (kind < 8) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
          line_buf.push_back(rtl_cp());
          for (j = 1; j < len; j++) begin
            if ($urandom_range(9) < 6) line_buf.push_back(rtl_cp());
            else line_buf.push_back(gap_cp());
          end
          repeat ($urandom_range(2)) line_buf.push_back(gap_cp());
        end else if (kind == 8) begin
          repeat ($urandom_range(3, 1)) begin
            noise = CP_W'($urandom);
            line_buf.push_back(noise);
          end
        end else begin
          line_buf.push_back(gap_cp());
        end
      end
      for (j = 0; j < line_buf.size(); j++) send_cp(line_buf[j], j + 1 == line_buf.size());
    end
  endtask

  initial begin : stimulus
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_RANGE_LOW;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    codepoint_i   <= '0;
    line_end_i    <= 1'b0;
    long_hold_req <= 1'b0;
    tx_idle_pct   = 26;
    rx_idle_pct   = 68;
    items_sent    = 0;
    cur_lo        = RANGE_LOW_RST;
    cur_hi        = RANGE_HIGH_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    set_range(RANGE_LOW_RST, RANGE_HIGH_RST);
    send_cp(21'h000041, 1'b0);
    send_cp(21'h000000, 1'b0);
    send_cp(CP_MAX, 1'b0);
    send_cp(21'h10FFFF, 1'b0);
    send_cp(CP_SPACE, 1'b0);
    send_cp(21'h00058F, 1'b0);
    send_cp(21'h000600, 1'b0);
    send_cp(RANGE_LOW_RST, 1'b0);
    send_cp(CP_SPACE, 1'b0);
    send_cp(RANGE_HIGH_RST, 1'b0);
    send_cp(CP_TAB, 1'b0);
    send_cp(CP_SPACE, 1'b0);
    send_cp(21'h000042, 1'b0);
    send_cp(21'h0005D0, 1'b1);
    send_cp(21'h0005D1, 1'b0);
    send_cp(CP_TAB, 1'b0);
    send_cp(21'h0005D2, 1'b0);
    send_cp(CP_SPACE, 1'b1);
    send_cp(21'h000043, 1'b1);
    send_cp(21'h0005D3, 1'b0);
    send_cp(CP_MAX, 1'b0);
    send_cp(CP_TAB, 1'b1);
    long_hold_req <= 1'b1;
    fill_lines(120);
    drain_results();

    set_range('0, CP_MAX);
    fill_lines(190);
    drain_results();

    tx_idle_pct = 68;
    rx_idle_pct = 26;
    set_range(CP_MAX, '0);
    fill_lines(240);
    drain_results();

    set_range(21'h000041, 21'h000041);
    fill_lines(310);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_range(21'h010000, CP_MAX);
    fill_lines(410);
    drain_results();

    $display("Sent %0d codepoints under five RTL ranges: default, full, inverted, single, upper.",
             items_sent);
    $display("Checked %0d results, %0d of them from runs cut by a full buffer.",
             results, overflows);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### rtl_run_reorder.f
hw/rtl/rr_pkg.sv
hw/rtl/rr_ram.sv
hw/rtl/rtl_run_reorder.sv
sim/rr_order_checker.sv
sim/tb.sv
